@@ design/lla_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the least-loaded agent table.
// Used by every module of the block; depends on nothing else.
package lla_pkg;

   localparam int NUM_SLOTS_DEFAULT = 16;
   localparam logic [7:0] LOAD_LIMIT_RESET = 8'd8;

   localparam logic [2:0] KIND_REGISTER   = 3'd0;
   localparam logic [2:0] KIND_CONNECT    = 3'd1;
   localparam logic [2:0] KIND_DISCONNECT = 3'd2;
   localparam logic [2:0] KIND_SELECT     = 3'd3;
   localparam logic [2:0] KIND_FIND       = 3'd4;

   localparam logic [1:0] ST_FREE = 2'd0;
   localparam logic [1:0] ST_REG  = 2'd1;
   localparam logic [1:0] ST_CONN = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] CSR_LOAD_LIMIT = 1'b0;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  slot;
      logic [15:0] addr_family;
      logic [31:0] ip_address;
      logic [15:0] port_number;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [3:0] result_slot;
      logic [7:0] slot_load;
   } rsp_type;

   typedef struct packed {
      logic [15:0] family;
      logic [31:0] ip;
      logic [15:0] port;
   } addr_type;

   typedef struct packed {
      logic       status_en;
      logic [1:0] status;
      logic       load_en;
      logic [7:0] load;
      logic       addr_en;
      addr_type   addr;
   } wr_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] load;
      addr_type   addr;
   } rd_type;

endpackage

@@ design/lla_slot_store.sv @@
`timescale 1ns / 1ps
// Slot table storage: status flops cleared by reset, load and address memories.
// Depends on lla_pkg for the read and write structures.
module lla_slot_store #(
   parameter int NUM_SLOTS = lla_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
   output lla_pkg::rd_type              rd_data,
   input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
   input  lla_pkg::wr_type              wr_cmd
);
   import lla_pkg::*;

   logic [1:0] status_ff [NUM_SLOTS];
   logic [7:0] load_mem [NUM_SLOTS];
   addr_type   addr_mem [NUM_SLOTS];
   logic [1:0] rd_status_ff;
   logic [7:0] rd_load_ff;
   addr_type   rd_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            status_ff[i] <= ST_FREE;
         end
      end else if (wr_cmd.status_en) begin
         status_ff[wr_addr] <= wr_cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      rd_status_ff <= status_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_cmd.load_en) begin
         load_mem[wr_addr] <= wr_cmd.load;
      end
      rd_load_ff <= load_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_cmd.addr_en) begin
         addr_mem[wr_addr] <= wr_cmd.addr;
      end
      rd_addr_ff <= addr_mem[rd_addr];
   end

   // A free slot has never been connected, so its load is zero.
   assign rd_data.status = rd_status_ff;
   assign rd_data.load   = (rd_status_ff == ST_FREE) ? 8'd0 : rd_load_ff;
   assign rd_data.addr   = rd_addr_ff;

endmodule

@@ design/lla_match_unit.sv @@
`timescale 1ns / 1ps
// Shared compare unit: decides whether the slot being scanned becomes the candidate.
// Depends on lla_pkg for the codes and the read structure.
module lla_match_unit (
   input  logic [2:0]      kind,
   input  lla_pkg::rd_type rd_data,
   input  lla_pkg::addr_type key,
   input  logic [7:0]      low,
   output logic            take
);
   import lla_pkg::*;

   always_comb begin
      case (kind)
         KIND_REGISTER: take = (rd_data.status == ST_FREE);
         KIND_SELECT:   take = (rd_data.status == ST_CONN) && (rd_data.load < low);
         KIND_FIND:     take = (rd_data.status != ST_FREE) && (rd_data.addr == key);
         default:       take = 1'b0;
      endcase
   end

endmodule

@@ design/least_loaded_agent_table.sv @@
`timescale 1ns / 1ps
// Top level of the least-loaded agent table: sequencer, control register, response register.
// Depends on lla_pkg, lla_slot_store and lla_match_unit.
//
//   Port group   Direction  Handshake                Payload
//   req_*        in         req_valid / req_stall    req_data (lla_pkg::req_type)
//   rsp_*        out        rsp_valid / rsp_stall    rsp_data (lla_pkg::rsp_type)
//   APB          in/out     psel, penable, pready    paddr, pwdata, prdata
//
// Register, select and find scan the table one slot per cycle through the shared compare
// unit and a registered memory read.
// Mark connected and mark disconnected read one slot.
// Reset clears all slot states to free and the load limit to 8; no clearing pass is needed.
// req_stall is high during reset and while a request is in progress; a stalled response holds the
// sequencer in its final step, and a new request may be taken while a response waits.
module least_loaded_agent_table #(
   parameter int NUM_SLOTS = lla_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  lla_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output lla_pkg::rsp_type             rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lla_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import lla_pkg::*;

   localparam int IdxW = $clog2(NUM_SLOTS);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MARK, S_FINISH} state_type;

   state_type       state_ff;
   req_type         req_ff;
   logic [IdxW-1:0] cnt_ff;
   logic [IdxW-1:0] chk_idx_ff;
   logic            have_ff;
   logic            show_ff;
   logic [IdxW-1:0] best_ff;
   logic [7:0]      best_load_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;
   logic [7:0]      limit_ff;

   logic [IdxW-1:0] rd_addr;
   rd_type          rd_data;
   wr_type          wr_cmd;
   addr_type        key;
   logic            take;
   logic            leave;
   logic            in_mark;
   logic            ff_mark;
   logic            ff_in_range;
   logic [IdxW+3:0] slot_wide_in;
   logic [IdxW+3:0] slot_wide_ff;
   logic [IdxW+3:0] best_wide;
   logic [3:0]      best_slot;
   logic [7:0]      load_next;
   logic            csr_write;

   assign in_mark      = (req_data.kind == KIND_CONNECT) || (req_data.kind == KIND_DISCONNECT);
   assign ff_mark      = (req_ff.kind == KIND_CONNECT) || (req_ff.kind == KIND_DISCONNECT);
   assign slot_wide_in = {{IdxW{1'b0}}, req_data.slot};
   assign slot_wide_ff = {{IdxW{1'b0}}, req_ff.slot};
   assign ff_in_range  = ({28'd0, req_ff.slot} < 32'(NUM_SLOTS));
   assign best_wide    = {4'd0, best_ff};
   assign best_slot    = best_wide[3:0];
   assign load_next    = best_load_ff + 8'd1;

   assign key.family = req_ff.addr_family;
   assign key.ip     = req_ff.ip_address;
   assign key.port   = req_ff.port_number;

   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = in_mark ? slot_wide_in[IdxW-1:0] : '0;
         S_SCAN:  rd_addr = cnt_ff;
         S_MARK:  rd_addr = cnt_ff;
         default: rd_addr = cnt_ff;
      endcase
   end

   lla_slot_store #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_addr (best_ff),
      .wr_cmd  (wr_cmd)
   );

   lla_match_unit u_match (
      .kind    (req_ff.kind),
      .rd_data (rd_data),
      .key     (key),
      .low     (best_load_ff),
      .take    (take)
   );

   assign leave = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // A newly registered slot starts with a zero load.
   always_comb begin
      wr_cmd           = '0;
      wr_cmd.addr      = key;
      wr_cmd.load      = (req_ff.kind == KIND_SELECT) ? load_next : 8'd0;
      wr_cmd.status    = (req_ff.kind == KIND_CONNECT) ? ST_CONN : ST_REG;
      if (leave && have_ff) begin
         case (req_ff.kind)
            KIND_REGISTER: begin
               wr_cmd.status_en = 1'b1;
               wr_cmd.addr_en   = 1'b1;
               wr_cmd.load_en   = 1'b1;
            end
            KIND_CONNECT:    wr_cmd.status_en = 1'b1;
            KIND_DISCONNECT: wr_cmd.status_en = 1'b1;
            KIND_SELECT:     wr_cmd.load_en   = 1'b1;
            default:         wr_cmd.status_en = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (leave) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff       <= req_data;
                  cnt_ff       <= IdxW'(1);
                  chk_idx_ff   <= '0;
                  have_ff      <= 1'b0;
                  show_ff      <= 1'b0;
                  best_ff      <= '0;
                  best_load_ff <= (req_data.kind == KIND_SELECT) ? limit_ff : 8'd0;
                  case (req_data.kind)
                     KIND_REGISTER:   state_ff <= S_SCAN;
                     KIND_SELECT:     state_ff <= S_SCAN;
                     KIND_FIND:       state_ff <= S_SCAN;
                     KIND_CONNECT:    state_ff <= S_MARK;
                     KIND_DISCONNECT: state_ff <= S_MARK;
                     default:         state_ff <= S_FINISH;
                  endcase
               end
            end
            S_SCAN: begin
               if (cnt_ff != LastIdx) begin
                  cnt_ff <= cnt_ff + IdxW'(1);
               end
               chk_idx_ff <= cnt_ff;
               if (take) begin
                  have_ff      <= 1'b1;
                  best_ff      <= chk_idx_ff;
                  best_load_ff <= rd_data.load;
               end
               if (chk_idx_ff == LastIdx) begin
                  state_ff <= S_FINISH;
               end
            end
            S_MARK: begin
               if (ff_mark && ff_in_range) begin
                  show_ff      <= 1'b1;
                  have_ff      <= (rd_data.status != ST_FREE);
                  best_ff      <= slot_wide_ff[IdxW-1:0];
                  best_load_ff <= rd_data.load;
               end
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (leave) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (leave) begin
         rsp_ff.found <= have_ff;
         if (have_ff || show_ff) begin
            rsp_ff.result_slot <= best_slot;
            rsp_ff.slot_load   <= (req_ff.kind == KIND_SELECT) ? load_next : best_load_ff;
         end else begin
            rsp_ff.result_slot <= 4'd0;
            rsp_ff.slot_load   <= 8'd0;
         end
      end
   end

   assign csr_write = psel && penable && pwrite && (paddr[2] == CSR_LOAD_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LOAD_LIMIT_RESET;
      end else if (csr_write) begin
         limit_ff <= pwdata[7:0];
      end
   end

   assign prdata    = (paddr[2] == CSR_LOAD_LIMIT) ? {24'd0, limit_ff} : 32'd0;
   assign pready    = 1'b1;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
